>>> hdl/task_interactivity_classifier_macros.svh
// Assertion macros shared by the checker files.
`ifndef TASK_INTERACTIVITY_CLASSIFIER_MACROS_SVH
`define TASK_INTERACTIVITY_CLASSIFIER_MACROS_SVH

// Antecedent in one cycle, consequent in the next; off during reset.
`define TIC_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("task_interactivity_classifier: assertion failed");

// Antecedent and consequent in the same cycle; off during reset.
`define TIC_ASSERT_NOW(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("task_interactivity_classifier: assertion failed");

// Check of the state right after reset.
`define TIC_ASSERT_RST(lbl, ck, rs, c) \
  lbl: assert property (@(posedge ck) (rs) |=> (c)) \
    else $error("task_interactivity_classifier: reset check failed");

`endif

>>> hdl/tic_pkg.sv
package tic_pkg;

  // table depth, kept a power of two so the task index is a plain bit slice
  localparam int TASKS  = 256;
  localparam int IDX_W  = $clog2(TASKS);
  localparam int QDEPTH = 2;

  localparam logic [29:0] NS_PER_SEC     = 30'd1000000000;
  localparam logic [29:0] BASE_SLICE_RST = 30'd5000000;
  localparam logic [9:0]  MAX_THRESH_RST = 10'd10;
  localparam logic [6:0]  CHARGE_SCALE   = 7'd100;
  localparam logic [13:0] RATE_STORE_MAX = 14'd16383;
  localparam logic [12:0] RATE_OUT_MAX   = 13'd8191;

  // configuration register indexes
  localparam logic REG_BASE_SLICE = 1'b0;
  localparam logic REG_MAX_THRESH = 1'b1;

  typedef enum logic [1:0] {
    FN_ENABLE   = 2'd0,
    FN_RUNNING  = 2'd1,
    FN_STOPPING = 2'd2,
    FN_NONE     = 2'd3
  } func_t;

  // classified item handed from the front to the back
  typedef struct packed {
    func_t             op;
    logic [IDX_W-1:0]  idx;
    logic [63:0]       now;
    logic [31:0]       count;
    logic [31:0]       slice;
    logic [13:0]       weight;
    logic [63:0]       vtime;
    logic              charge;
    logic [36:0]       charge_num;
  } item_t;

  // one task table entry
  typedef struct packed {
    logic [31:0] count;
    logic [63:0] stamp;
    logic [13:0] rate;
    logic        inter;
  } entry_t;

endpackage

>>> hdl/tic_front.sv
module tic_front (
  input  logic [1:0]   func,
  input  logic [7:0]   task_id,
  input  logic [63:0]  now_ns,
  input  logic [31:0]  switch_count,
  input  logic [31:0]  slice_left_ns,
  input  logic [13:0]  task_weight,
  input  logic [63:0]  vtime_in,
  input  logic [29:0]  base_slice,
  output tic_pkg::item_t item
);

  logic [29:0] slice_diff;

  // unused slice, valid only when the base slice exceeds the slice left
  assign slice_diff = base_slice - slice_left_ns[29:0];

  always_comb begin
    item.op     = tic_pkg::func_t'(func);
    item.idx    = task_id[tic_pkg::IDX_W-1:0];
    item.now    = now_ns;
    item.count  = switch_count;
    item.weight = (task_weight == 14'd0) ? 14'd1 : task_weight;
    item.vtime  = vtime_in;
    item.charge = ({2'b00, base_slice} > slice_left_ns);
    item.charge_num = {7'd0, slice_diff} * {30'd0, tic_pkg::CHARGE_SCALE};
    // running caps the slice at the base slice
    if (item.op == tic_pkg::FN_RUNNING && slice_left_ns > {2'b00, base_slice}) begin
      item.slice = {2'b00, base_slice};
    end else begin
      item.slice = slice_left_ns;
    end
  end

endmodule

>>> hdl/tic_fifo.sv
module tic_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  tic_pkg::item_t din,
  input  logic           rd,
  output tic_pkg::item_t dout,
  output logic           full,
  output logic           nempty
);

  localparam int PTR_W = (tic_pkg::QDEPTH > 1) ? $clog2(tic_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(tic_pkg::QDEPTH + 1);

  tic_pkg::item_t   slots [tic_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;

  assign full   = (cnt == CNT_W'(tic_pkg::QDEPTH));
  assign nempty = (cnt != '0);
  assign dout   = slots[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= din;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PTR_W'(tic_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && nempty) begin
        rptr <= (rptr == PTR_W'(tic_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if ((wr && !full) && !(rd && nempty)) begin
        cnt <= cnt + 1'b1;
      end else if (!(wr && !full) && (rd && nempty)) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

>>> hdl/tic_div.sv
module tic_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] q
);

  logic [63:0] rem;
  logic [63:0] divisor;
  logic [5:0]  cnt;
  logic        run;
  logic [64:0] trial;

  // restoring step: one quotient bit per cycle, dividend bits leave q at the top
  assign trial = {rem, q[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      q       <= a;
      divisor <= b;
    end else if (run) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], q[63]};
        q   <= {q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/tic_back.sv
module tic_back (
  input  logic           clk,
  input  logic           rst,
  input  tic_pkg::item_t head,
  input  logic           head_valid,
  output logic           head_pop,
  input  logic [9:0]     max_thresh,
  input  logic           pop,
  output logic           empty,
  output logic [63:0]    vtime_out,
  output logic [31:0]    slice_out_ns,
  output logic           interactive,
  output logic [12:0]    task_rate_avg,
  output logic [9:0]     global_thresh
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOOK  = 8'b00000010,
    S_PREP  = 8'b00000100,
    S_CHG   = 8'b00001000,
    S_ROUTE = 8'b00010000,
    S_RATE  = 8'b00100000,
    S_EWMA  = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t          state;
  tic_pkg::item_t  cur;
  tic_pkg::entry_t table_mem [tic_pkg::TASKS];
  tic_pkg::entry_t rd_data;
  tic_pkg::entry_t ent;
  logic [63:0]     dt;
  logic [31:0]     dsw;
  logic [61:0]     prod;
  logic            cond;
  logic            wr_pend;
  logic [63:0]     vacc;
  logic [63:0]     gvt;
  logic [9:0]      gthr;
  logic            out_valid;
  logic            out_free;
  logic            mem_we;

  logic            div_start;
  logic [63:0]     div_a;
  logic [63:0]     div_b;
  logic            div_done;
  logic [63:0]     div_q;
  logic            rate_go;
  logic [13:0]     seed;
  logic [63:0]     t_sum;
  logic [63:0]     g_sum;
  logic [12:0]     t_hi;
  logic [13:0]     t_new;
  logic [9:0]      g_new;

  function automatic logic gvt_behind(input logic [63:0] g, input logic [63:0] v);
    logic [63:0] d;
    d = g - v;
    return d[63];
  endfunction

  assign head_pop = (state == S_IDLE) && head_valid;
  assign out_free = !out_valid || pop;
  assign mem_we   = (state == S_FIN) && wr_pend && out_free;
  assign empty    = !out_valid;

  // rate division needed: seeding with a nonzero time, or a due rate sample
  assign rate_go = ((cur.op == tic_pkg::FN_ENABLE) && (cur.now != 64'd0)) ||
                   ((cur.op == tic_pkg::FN_STOPPING) && cond);

  // shared divider: weighted charge first, then the switch rate
  assign div_start = ((state == S_PREP) && (cur.op == tic_pkg::FN_STOPPING) && cur.charge) ||
                     ((state == S_ROUTE) && rate_go);
  assign div_a = (state == S_PREP) ? {27'd0, cur.charge_num} : {2'b00, prod};
  assign div_b = (state == S_PREP) ? {50'd0, cur.weight} :
                 ((cur.op == tic_pkg::FN_ENABLE) ? cur.now : dt);

  tic_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  // seed saturates in the 14-bit store
  assign seed = (div_q > 64'(tic_pkg::RATE_STORE_MAX)) ? tic_pkg::RATE_STORE_MAX
                                                      : div_q[13:0];

  // averages: old - old/4 + sample/4, then clamped
  assign t_sum = 64'(ent.rate - (ent.rate >> 2)) + (div_q >> 2);
  assign g_sum = 64'(gthr - (gthr >> 2)) + (div_q >> 2);
  assign t_hi  = {max_thresh, 3'b000};
  assign t_new = (t_sum > 64'(t_hi)) ? {1'b0, t_hi} : t_sum[13:0];
  always_comb begin
    if (g_sum < 64'd1) begin
      g_new = 10'd1;
    end else if (g_sum > 64'(max_thresh)) begin
      g_new = max_thresh;
    end else begin
      g_new = g_sum[9:0];
    end
  end

  // task table, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[cur.idx] <= ent;
    end
    if (head_pop) begin
      rd_data <= table_mem[head.idx];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (head_pop) begin
          cur <= head;
        end
      end
      S_LOOK: begin
        ent  <= rd_data;
        dt   <= cur.now - rd_data.stamp;
        dsw  <= cur.count - rd_data.count;
        vacc <= (cur.op == tic_pkg::FN_ENABLE) ? gvt : cur.vtime;
      end
      S_PREP: begin
        prod <= ((cur.op == tic_pkg::FN_ENABLE) ? cur.count : dsw) * tic_pkg::NS_PER_SEC;
        cond <= (max_thresh != 10'd0) && !dt[63] && (dt > 64'(tic_pkg::NS_PER_SEC));
      end
      S_CHG: begin
        if (div_done) begin
          vacc <= vacc + div_q;
        end
      end
      S_ROUTE: begin
        if (!rate_go && cur.op == tic_pkg::FN_ENABLE) begin
          ent <= '{count: cur.count, stamp: cur.now, rate: 14'd0, inter: (gthr == 10'd0)};
        end
      end
      S_RATE: begin
        if (div_done && cur.op == tic_pkg::FN_ENABLE) begin
          ent <= '{count: cur.count, stamp: cur.now, rate: seed,
                   inter: (seed >= {4'd0, gthr})};
        end
      end
      S_EWMA: begin
        ent <= '{count: cur.count, stamp: cur.now, rate: t_new,
                 inter: (t_new >= {4'd0, g_new})};
      end
      S_FIN: begin
        if (out_free) begin
          vtime_out     <= vacc;
          slice_out_ns  <= cur.slice;
          interactive   <= ent.inter;
          task_rate_avg <= (ent.rate > {1'b0, tic_pkg::RATE_OUT_MAX}) ?
                           tic_pkg::RATE_OUT_MAX : ent.rate[12:0];
          global_thresh <= gthr;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and global state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
      gthr      <= 10'd0;
      gvt       <= 64'd0;
    end else begin
      // output register: loaded at the last step, freed on pop
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_pop) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_PREP;
        end
        S_PREP: begin
          // running: wrap-safe advance of the global vtime
          if (cur.op == tic_pkg::FN_RUNNING && gvt_behind(gvt, cur.vtime)) begin
            gvt <= cur.vtime;
          end
          if (cur.op == tic_pkg::FN_STOPPING && cur.charge) begin
            state <= S_CHG;
          end else begin
            state <= S_ROUTE;
          end
        end
        S_CHG: begin
          if (div_done) begin
            state <= S_ROUTE;
          end
        end
        S_ROUTE: begin
          if (rate_go) begin
            state <= S_RATE;
          end else begin
            wr_pend <= (cur.op == tic_pkg::FN_ENABLE);
            state   <= S_FIN;
          end
        end
        S_RATE: begin
          if (div_done) begin
            if (cur.op == tic_pkg::FN_ENABLE) begin
              wr_pend <= 1'b1;
              state   <= S_FIN;
            end else begin
              state <= S_EWMA;
            end
          end
        end
        S_EWMA: begin
          gthr    <= g_new;
          wr_pend <= 1'b1;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            wr_pend <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/task_interactivity_classifier.sv
// Task interactivity classifier.
// Input channel: push/full. A transaction is taken at a rising edge with push
// high and full low; func selects enable (seed an entry), running (advance the
// global vtime, cap the slice) or stopping (charge the used slice, refresh
// the switch-rate averages and the class).
// Result channel: empty/pop. Exactly one result per input, in order; the
// oldest result sits on the ports while empty is low and leaves on pop.
// Configuration: cfg_wr/cfg_index/cfg_data, written while the block is idle.
// The bit-serial divider serves both the weighted charge and the rate
// division, one after the other.
// Items are worked one at a time; a two-entry input queue keeps accepting
// while the back end is busy or a result waits in the output register.
// Reset (rst, synchronous) empties the queue and the output, clears the
// global threshold and vtime and restores the register defaults; the task
// table is not cleared and each entry must be enabled before use.
// A stalled receiver holds the result; the back end then stops at its last
// step and the queue fills, raising full.
module task_interactivity_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [7:0]  task_id,
  input  logic [63:0] now_ns,
  input  logic [31:0] switch_count,
  input  logic [31:0] slice_left_ns,
  input  logic [13:0] task_weight,
  input  logic [63:0] vtime_in,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] vtime_out,
  output logic [31:0] slice_out_ns,
  output logic        interactive,
  output logic [12:0] task_rate_avg,
  output logic [9:0]  global_thresh,
  input  logic        cfg_wr,
  input  logic        cfg_index,
  input  logic [29:0] cfg_data
);

  logic [29:0]    base_slice;
  logic [9:0]     max_thresh;
  tic_pkg::item_t item;
  tic_pkg::item_t head;
  logic           head_valid;
  logic           head_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_slice <= tic_pkg::BASE_SLICE_RST;
      max_thresh <= tic_pkg::MAX_THRESH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        tic_pkg::REG_BASE_SLICE: base_slice <= cfg_data;
        tic_pkg::REG_MAX_THRESH: max_thresh <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  tic_front u_front (
    .func          (func),
    .task_id       (task_id),
    .now_ns        (now_ns),
    .switch_count  (switch_count),
    .slice_left_ns (slice_left_ns),
    .task_weight   (task_weight),
    .vtime_in      (vtime_in),
    .base_slice    (base_slice),
    .item          (item)
  );

  tic_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push),
    .din    (item),
    .rd     (head_pop),
    .dout   (head),
    .full   (full),
    .nempty (head_valid)
  );

  tic_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .head_pop      (head_pop),
    .max_thresh    (max_thresh),
    .pop           (pop),
    .empty         (empty),
    .vtime_out     (vtime_out),
    .slice_out_ns  (slice_out_ns),
    .interactive   (interactive),
    .task_rate_avg (task_rate_avg),
    .global_thresh (global_thresh)
  );

endmodule

>>> hdl/tic_checker.sv
`include "task_interactivity_classifier_macros.svh"

module tic_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [63:0] vtime_out
);

  logic [3:0] outstanding;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {3'd0, (push && !full)} - {3'd0, (pop && !empty)};
    end
  end

  `TIC_ASSERT_RST(a_reset_idle, clk, rst, empty && !full)
  `TIC_ASSERT_NOW(a_no_invented_result, clk, rst, !empty, outstanding != 4'd0)
  `TIC_ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty)
  `TIC_ASSERT_NEXT(a_result_stable, clk, rst, !empty && !pop, $stable(vtime_out))

endmodule

bind task_interactivity_classifier tic_checker u_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // one input transaction
  typedef struct {
    tic_pkg::func_t op;
    bit [7:0]    task_id;
    bit [63:0]   now;
    bit [31:0]   count;
    bit [31:0]   slice;
    bit [13:0]   weight;
    bit [63:0]   vtime;
  } sched_op_t;

  // one result transaction
  typedef struct {
    bit [63:0]   vtime;
    bit [31:0]   slice;
    bit          inter;
    bit [12:0]   rate;
    bit [9:0]    thresh;
  } sched_res_t;

  localparam bit [63:0] ONE_SEC = 64'd1000000000;
  localparam int        NTASK   = 16;
  localparam int        WD_MAX  = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  func = '0;
  logic [7:0]  task_id = '0;
  logic [63:0] now_ns = '0;
  logic [31:0] switch_count = '0;
  logic [31:0] slice_left_ns = '0;
  logic [13:0] task_weight = '0;
  logic [63:0] vtime_in = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] vtime_out;
  logic [31:0] slice_out_ns;
  logic        interactive;
  logic [12:0] task_rate_avg;
  logic [9:0]  global_thresh;
  logic        cfg_wr = 1'b0;
  logic        cfg_index = tic_pkg::REG_BASE_SLICE;
  logic [29:0] cfg_data = '0;

  task_interactivity_classifier u_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  bit [31:0] tab_count [256];
  bit [63:0] tab_stamp [256];
  bit [13:0] tab_rate  [256];
  bit        tab_inter [256];
  bit [9:0]  thr_q;
  bit [63:0] gvtime_q;
  bit [29:0] base_slice_q = tic_pkg::BASE_SLICE_RST;
  bit [9:0]  max_thresh_q = tic_pkg::MAX_THRESH_RST;

  sched_op_t  pending_q [$];
  sched_res_t expected_q [$];
  int  errors = 0;
  bit  calm = 0;
  bit  hold_ask = 0;
  bit  hold_taken = 0;
  int  hold_left = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  stall_cnt = 0;

  // generator bookkeeping
  bit [7:0]  ids [NTASK];
  bit [31:0] gen_count [NTASK];
  bit [63:0] t_now = 64'd1000;

  function automatic bit [63:0] ewma(bit [63:0] old_v, bit [63:0] sample,
                                     bit [63:0] lo, bit [63:0] hi);
    bit [63:0] v;
    v = (old_v - (old_v >> 2)) + (sample >> 2);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // work out the result of one transaction and update the tracked state
  function automatic sched_res_t classify(sched_op_t it);
    sched_res_t r;
    bit [63:0] seed, dt, sample, t, vt, sl, w, base, diff;
    bit [31:0] dsw;
    bit [7:0]  ix;
    ix = it.task_id;
    w = (it.weight == 0) ? 64'd1 : 64'(it.weight);
    vt = it.vtime;
    sl = 64'(it.slice);
    base = 64'(base_slice_q);
    case (it.op)
      tic_pkg::FN_ENABLE: begin
        seed = 0;
        if (it.now != 0) begin
          seed = (64'(it.count) * ONE_SEC) / it.now;
          if (seed > 64'd16383) seed = 64'd16383;
        end
        tab_count[ix] = it.count;
        tab_stamp[ix] = it.now;
        tab_rate[ix] = seed[13:0];
        tab_inter[ix] = (seed >= 64'(thr_q));
        vt = gvtime_q;
      end
      tic_pkg::FN_RUNNING: begin
        diff = gvtime_q - vt;
        if (diff[63]) gvtime_q = vt;
        if (sl > base) sl = base;
      end
      tic_pkg::FN_STOPPING: begin
        dt = it.now - tab_stamp[ix];
        if (base > sl) vt = vt + ((base - sl) * 64'd100) / w;
        if (max_thresh_q != 0 && !dt[63] && dt > ONE_SEC) begin
          dsw = it.count - tab_count[ix];
          sample = (64'(dsw) * ONE_SEC) / dt;
          t = ewma(64'(tab_rate[ix]), sample, 0, 64'(max_thresh_q) << 3);
          tab_rate[ix] = t[13:0];
          tab_count[ix] = it.count;
          tab_stamp[ix] = it.now;
          thr_q = 10'(ewma(64'(thr_q), sample, 1, 64'(max_thresh_q)));
          tab_inter[ix] = (t >= 64'(thr_q));
        end
      end
      default: ;
    endcase
    r.vtime = vt;
    r.slice = sl[31:0];
    r.inter = tab_inter[ix];
    r.rate = (tab_rate[ix] > 14'd8191) ? 13'd8191 : tab_rate[ix][12:0];
    r.thresh = thr_q;
    return r;
  endfunction

  // driver: next offer goes out on the falling edge
  always @(negedge clk) begin
    if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      push <= 1'b0;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      send_gap <= $urandom_range(1, 10);
      push <= 1'b0;
    end else if (pending_q.size() > 0 && !rst) begin
      push <= 1'b1;
      func <= pending_q[0].op;
      task_id <= pending_q[0].task_id;
      now_ns <= pending_q[0].now;
      switch_count <= pending_q[0].count;
      slice_left_ns <= pending_q[0].slice;
      task_weight <= pending_q[0].weight;
      vtime_in <= pending_q[0].vtime;
    end else begin
      push <= 1'b0;
    end
  end

  // receiver stalls: random bursts plus one long hold-off
  always @(negedge clk) begin
    if (hold_ask && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 19) == 0) begin
      recv_gap <= $urandom_range(1, 10);
      pop <= 1'b0;
    end else begin
      pop <= !rst;
    end
  end

  // accepted input transactions feed the predictor
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      expected_q.push_back(classify(pending_q[0]));
      void'(pending_q.pop_front());
    end
  end

  // accepted results are compared with the oldest expectation
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, vtime %h", $time, vtime_out);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (vtime_out !== e.vtime || slice_out_ns !== e.slice ||
            interactive !== e.inter || task_rate_avg !== e.rate ||
            global_thresh !== e.thresh) begin
          $display("%0t: exp vt=%h sl=%0d int=%0d rate=%0d thr=%0d", $time,
                   e.vtime, e.slice, e.inter, e.rate, e.thresh);
          $display("%0t: got vt=%h sl=%0d int=%0d rate=%0d thr=%0d", $time,
                   vtime_out, slice_out_ns, interactive, task_rate_avg,
                   global_thresh);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with work outstanding but no transaction
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) ||
        (pending_q.size() == 0 && expected_q.size() == 0)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WD_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic add_op(tic_pkg::func_t op, bit [7:0] id, bit [63:0] now, bit [31:0] cnt,
                        bit [31:0] sl, bit [13:0] w, bit [63:0] vt);
    sched_op_t it;
    it.op = op; it.task_id = id; it.now = now; it.count = cnt;
    it.slice = sl; it.weight = w; it.vtime = vt;
    pending_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [29:0] val);
    @(negedge clk);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == tic_pkg::REG_BASE_SLICE) base_slice_q = val;
    else max_thresh_q = val[9:0];
    @(negedge clk);
    cfg_wr <= 1'b0;
  endtask

  // mostly well-formed traffic on the tracked tasks, some noise
  task automatic random_phase(int n);
    int k;
    bit [7:0] id;
    bit [63:0] nw;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, NTASK - 1);
      id = ids[k];
      t_now = t_now + $urandom_range(0, 400000000);
      nw = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} : t_now;
      gen_count[k] = gen_count[k] + $urandom_range(0, 3000);
      case ($urandom_range(0, 9))
        0: add_op(tic_pkg::FN_ENABLE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : id,
                  nw, ($urandom_range(0, 3) == 0) ? $urandom : gen_count[k],
                  $urandom, 14'($urandom), {$urandom, $urandom});
        1, 2, 3: add_op(tic_pkg::FN_RUNNING, id, nw, $urandom,
                        ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 9000000),
                        14'($urandom), {$urandom, $urandom});
        9: add_op(tic_pkg::FN_NONE, id, nw, $urandom, $urandom, 14'($urandom),
                  {$urandom, $urandom});
        default: add_op(tic_pkg::FN_STOPPING, id, nw, gen_count[k],
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6000000),
                        14'($urandom_range(0, 16383)), {$urandom, $urandom});
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: enables first, so that no entry is read unwritten
    for (int k = 0; k < NTASK; k++) begin
      ids[k] = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom);
      gen_count[k] = $urandom_range(0, 1000);
    end
    add_op(tic_pkg::FN_ENABLE, 8'd0, 64'd0, 32'd500, 32'd0, 14'd1, 64'd0);
    add_op(tic_pkg::FN_ENABLE, 8'd255, 64'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 14'h3FFF, '1);
    for (int k = 2; k < NTASK; k++)
      add_op(tic_pkg::FN_ENABLE, ids[k], t_now, gen_count[k], 32'd0, 14'd100, 64'd0);
    add_op(tic_pkg::FN_RUNNING, 8'd0, 64'd0, 32'd0, 32'hFFFFFFFF, 14'd1, 64'd100);
    add_op(tic_pkg::FN_RUNNING, 8'd0, 64'd0, 32'd0, 32'd5, 14'd1, 64'h8000000000000005);
    add_op(tic_pkg::FN_RUNNING, 8'd255, 64'd0, 32'd0, 32'd5000000, 14'd1, '1);
    add_op(tic_pkg::FN_STOPPING, 8'd0, 64'd3000000000, 32'd400, 32'd0, 14'd0, 64'd7);
    add_op(tic_pkg::FN_STOPPING, 8'd255, '1, 32'd0, 32'hFFFFFFFF, 14'h3FFF, '1);
    add_op(tic_pkg::FN_STOPPING, 8'd255, 64'd2000000002, 32'd5, 32'd1, 14'd10000, 64'd0);
    add_op(tic_pkg::FN_NONE, 8'd0, '1, '1, 32'd1234, 14'd0, 64'hDEADBEEF);
    wait_idle();

    // settings, extremes among them
    write_reg(tic_pkg::REG_BASE_SLICE, 30'd5000000);
    write_reg(tic_pkg::REG_MAX_THRESH, 10'd10);
    random_phase(120);
    hold_ask = 1;
    wait_idle();
    write_reg(tic_pkg::REG_BASE_SLICE, 30'd0);
    write_reg(tic_pkg::REG_MAX_THRESH, 10'd1023);
    random_phase(120);
    wait_idle();
    write_reg(tic_pkg::REG_BASE_SLICE, 30'd1000000000);
    write_reg(tic_pkg::REG_MAX_THRESH, 10'd0);
    random_phase(120);
    wait_idle();
    write_reg(tic_pkg::REG_BASE_SLICE, 30'd3000000);
    write_reg(tic_pkg::REG_MAX_THRESH, 10'd1);
    random_phase(120);
    wait_idle();
    write_reg(tic_pkg::REG_BASE_SLICE, 30'd8000000);
    write_reg(tic_pkg::REG_MAX_THRESH, 10'd200);
    random_phase(100);
    wait_idle();
    calm = 1;
    random_phase(100);
    wait_idle();
    repeat (200) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
